// ===== design/mma_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the matrix multiply-accumulate block.
// No dependencies; the top level and mma_mac import this package.
package mma_pkg;

	localparam int VALUE_W = 16;
	localparam int POS_W   = 3;
	localparam int SIZE_W  = 4;
	localparam int PROD_W  = 32;
	localparam int ACC_W   = 36;
	localparam int FRAC_W  = 8;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

	localparam logic [1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [1:0] CMD_LOAD_C  = 2'd2;
	localparam logic [1:0] CMD_COMPUTE = 2'd3;

	typedef struct packed {
		logic [1:0]                command;
		logic [POS_W-1:0]          row;
		logic [POS_W-1:0]          column;
		logic signed [VALUE_W-1:0] value;
	} mma_item_t;

	typedef struct packed {
		logic [POS_W-1:0]          out_row;
		logic [POS_W-1:0]          out_column;
		logic signed [VALUE_W-1:0] out_value;
		logic                      last;
	} mma_result_t;

	// Travels with each product term through the shared MAC.
	typedef struct packed {
		logic             first;
		logic             last_k;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] column;
		logic             last;
	} mma_tag_t;

	typedef struct packed {
		logic     pending;
		logic     done;
		mma_tag_t tag;
	} mma_mac_stat_t;

	// Floor shift by FRAC_W (arithmetic) then clamp to 16 bits.
	function automatic logic signed [VALUE_W-1:0] sat_q88(input logic signed [ACC_W-1:0] acc);
		logic [ACC_W-VALUE_W-FRAC_W:0] top;
		logic signed [VALUE_W-1:0]     res;
		top = acc[ACC_W-1:VALUE_W+FRAC_W-1];
		if (top == '0 || top == '1) begin
			res = acc[VALUE_W+FRAC_W-1:FRAC_W];
		end else if (acc[ACC_W-1]) begin
			res = {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(VALUE_W-1){1'b1}}};
		end
		return res;
	endfunction

endpackage

// ===== design/matrix_multiply_accumulate_top.sv =====
`timescale 1ns / 1ps
// Square matrix multiply-accumulate C = C + A*B in signed Q8.8.
// Uses mma_pkg, mma_ram (three element stores) and mma_mac.
//
// Usage:
//   Items are accepted on a rising edge with start high and busy low. Loads
//   (A, B or C element) write the store in that edge and give no result;
//   busy stays low, so loads can go one per cycle. A load with row or column
//   at or above MAX_SIZE is dropped.
//   A compute beat raises busy. With n = min(matrix_size, MAX_SIZE), the
//   sequencer walks (row, column, k) through one shared multiplier and
//   accumulator, one product term per cycle. Each term passes through the
//   store read registers, the product register and the accumulator, and each
//   C element through the result register; busy falls after the last result.
//   Results come row-major on result, one cycle each, marked by strobe,
//   last set on the final one; each is also written back into the C store.
//   The receiver cannot stall: every strobe beat is taken.
//   matrix_size is written on cfg_valid/cfg_ready while idle; n = 0 makes a
//   compute a no-op.
//   Reset: matrix_size returns to 8, the sequencer idles, strobe is low.
//   The element stores hold no reset value: load before computing.
module matrix_multiply_accumulate_top
	import mma_pkg::*;
#(
	parameter int MAX_SIZE = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mma_item_t         item,
	output logic              strobe,
	output mma_result_t       result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] cfg_data
);

	localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
	localparam int IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [SIZE_W-1:0] MAX_N = SIZE_W'(MAX_SIZE);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]        state_q;
	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] n_q;
	logic [SIZE_W-1:0] n_eff;
	logic [IDX_W-1:0]  i_q, j_q, k_q;
	logic              valid_s1;
	mma_tag_t          tag_s0, tag_s1;
	logic              strobe_q;
	mma_result_t       result_q;

	logic                      accept;
	logic                      in_range;
	logic [ADDR_W-1:0]         load_addr;
	logic [ADDR_W-1:0]         addr_a, addr_b, addr_c;
	logic                      we_a, we_b, we_c;
	logic [ADDR_W-1:0]         waddr_c;
	logic [VALUE_W-1:0]        wdata_c;
	logic [VALUE_W-1:0]        a_s1, b_s1, c_s1;
	logic                      k_end, j_end, i_end;
	mma_mac_stat_t             mac_stat;
	logic signed [ACC_W-1:0]   mac_acc;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign n_eff     = (size_q > MAX_N) ? MAX_N : size_q;

	assign in_range  = ({1'b0, item.row} < MAX_N) && ({1'b0, item.column} < MAX_N);
	assign load_addr = ADDR_W'(int'(item.row) * MAX_SIZE + int'(item.column));

	assign addr_a = ADDR_W'(int'(i_q) * MAX_SIZE + int'(k_q));
	assign addr_b = ADDR_W'(int'(k_q) * MAX_SIZE + int'(j_q));
	assign addr_c = ADDR_W'(int'(i_q) * MAX_SIZE + int'(j_q));

	assign we_a = accept && in_range && item.command == CMD_LOAD_A;
	assign we_b = accept && in_range && item.command == CMD_LOAD_B;
	// C port is shared by loads and result write-back; the two never meet
	// because busy only falls once the last result has gone out.
	assign we_c    = (accept && in_range && item.command == CMD_LOAD_C) || strobe_q;
	assign waddr_c = strobe_q
		? ADDR_W'(int'(result_q.out_row) * MAX_SIZE + int'(result_q.out_column))
		: load_addr;
	assign wdata_c = strobe_q ? result_q.out_value : item.value;

	assign k_end = (SIZE_W'(k_q) == n_q - 1'b1);
	assign j_end = (SIZE_W'(j_q) == n_q - 1'b1);
	assign i_end = (SIZE_W'(i_q) == n_q - 1'b1);

	always_comb begin
		tag_s0.first  = (k_q == '0);
		tag_s0.last_k = k_end;
		tag_s0.row    = POS_W'(i_q);
		tag_s0.column = POS_W'(j_q);
		tag_s0.last   = i_end && j_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			size_q   <= SIZE_RESET;
			n_q      <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			valid_s1 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_RUN);
			strobe_q <= mac_stat.done;
			if (cfg_valid && cfg_ready) begin
				size_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && item.command == CMD_COMPUTE && n_eff != '0) begin
						n_q     <= n_eff;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (!k_end) begin
						k_q <= k_q + 1'b1;
					end else begin
						k_q <= '0;
						if (!j_end) begin
							j_q <= j_q + 1'b1;
						end else begin
							j_q <= '0;
							i_q <= i_q + 1'b1;
							if (i_end) begin
								state_q <= ST_DRAIN;
							end
						end
					end
				end
				ST_DRAIN: begin
					if (!valid_s1 && !mac_stat.pending && !mac_stat.done && !strobe_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= tag_s0;
		if (mac_stat.done) begin
			result_q.out_row    <= mac_stat.tag.row;
			result_q.out_column <= mac_stat.tag.column;
			result_q.out_value  <= sat_q88(mac_acc);
			result_q.last       <= mac_stat.tag.last;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	mma_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(VALUE_W)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (load_addr),
		.wdata (item.value),
		.raddr (addr_a),
		.rdata (a_s1)
	);

	mma_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(VALUE_W)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (load_addr),
		.wdata (item.value),
		.raddr (addr_b),
		.rdata (b_s1)
	);

	mma_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(VALUE_W)) u_ram_c (
		.clk   (clk),
		.we    (we_c),
		.waddr (waddr_c),
		.wdata (wdata_c),
		.raddr (addr_c),
		.rdata (c_s1)
	);

	mma_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.tag_s1   (tag_s1),
		.a_s1     (a_s1),
		.b_s1     (b_s1),
		.c_s1     (c_s1),
		.stat     (mac_stat),
		.acc      (mac_acc)
	);

`ifndef SYNTHESIS
	// Result beats only come out of an active compute.
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result beat while idle");

	// Nothing follows the final element of a matrix.
	a_last_alone: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |=> !strobe)
		else $error("result beat after last");

	// A C load must never collide with a write-back on the shared C port.
	a_c_port: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.command == CMD_LOAD_C |-> !strobe_q)
		else $error("C load collides with write-back");

	// A compute with a nonzero size always takes the block busy.
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.command == CMD_COMPUTE && n_eff != '0 |=> busy)
		else $error("compute beat did not start the sequencer");
`endif

endmodule

// ===== design/mma_ram.sv =====
`timescale 1ns / 1ps
// Element store: one write port, one read port with registered read data.
// Depends on nothing; instanced once per matrix by the top level.
module mma_ram #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/mma_mac.sv =====
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: registered 16x16 product, then a 36-bit
// accumulate seeded with C*256 on the first term. Depends on mma_pkg.
module mma_mac
	import mma_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s1,
	input  mma_tag_t                  tag_s1,
	input  logic signed [VALUE_W-1:0] a_s1,
	input  logic signed [VALUE_W-1:0] b_s1,
	input  logic signed [VALUE_W-1:0] c_s1,
	output mma_mac_stat_t             stat,
	output logic signed [ACC_W-1:0]   acc
);

	logic                      valid_s2;
	mma_tag_t                  tag_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [VALUE_W-1:0] c_s2;
	logic                      done_q;
	mma_tag_t                  tag_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   base;
	logic signed [ACC_W-1:0]   sum;

	always_comb begin
		base = tag_s2.first ? {{(ACC_W-VALUE_W-FRAC_W){c_s2[VALUE_W-1]}}, c_s2, {FRAC_W{1'b0}}}
		                    : acc_q;
		sum  = base + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
			acc_q    <= '0;
		end else begin
			valid_s2 <= valid_s1;
			done_q   <= valid_s2 && tag_s2.last_k;
			if (valid_s2) begin
				acc_q <= sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
		c_s2    <= c_s1;
		tag_s2  <= tag_s1;
		tag_q   <= tag_s2;
	end

	assign stat.pending = valid_s2;
	assign stat.done    = done_q;
	assign stat.tag     = tag_q;
	assign acc          = acc_q;

endmodule
